/* rtl/core/srr_pkg.sv */
// ----------------------------------------------------------------------------
// Selective-repeat receiver package
// Widths, window constants, result kinds and the command passed from the
// classifier to the result stage.
// ----------------------------------------------------------------------------
package srr_pkg;

  // Window size. It must be a power of two so the ring index wraps naturally.
  localparam int WINDOW   = 32;
  localparam int IDX_W    = $clog2(WINDOW);
  localparam int MAX_SEG  = 1464;

  localparam int SEQ_W    = 31;
  localparam int TAG_W    = 16;
  localparam int LEN_W    = 11;
  localparam int CNT_W    = 32;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_STOP    = 2'd1,
    KIND_DELIVER = 2'd2
  } kind_e;

  // One command for the result stage: an ack, a stop ack or a delivery.
  typedef struct packed {
    kind_e              kind;
    logic [SEQ_W-1:0]   value;   // acked sequence, or announced total
    logic [TAG_W-1:0]   tag;
    logic [LEN_W-1:0]   len;
    logic               last;
  } cmd_t;

endpackage

/* rtl/core/srr_if.sv */
// ----------------------------------------------------------------------------
// Selective-repeat receiver channels
// Valid/ready channels for segment headers and for result items.
// ----------------------------------------------------------------------------
interface srr_seg_if import srr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             finish;
  logic [SEQ_W-1:0] seq_num;
  logic [SEQ_W-1:0] seg_length;
  logic [TAG_W-1:0] payload_tag;

  modport source (output valid, finish, seq_num, seg_length, payload_tag,
                  input ready);
  modport sink   (input valid, finish, seq_num, seg_length, payload_tag,
                  output ready);
endinterface

interface srr_res_if import srr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [SEQ_W-1:0] ack_seq;
  logic [TAG_W-1:0] deliver_tag;
  logic [LEN_W-1:0] deliver_length;
  logic [CNT_W-1:0] bytes_delivered;
  logic             done_res;
  logic             last;

  modport source (output valid, kind, ack_seq, deliver_tag, deliver_length,
                  bytes_delivered, done_res, last, input ready);
  modport sink   (input valid, kind, ack_seq, deliver_tag, deliver_length,
                  bytes_delivered, done_res, last, output ready);
endinterface

/* rtl/core/srr_front.sv */
// ----------------------------------------------------------------------------
// Selective-repeat receiver front end
// Accepts segment headers, classifies them against the window, stores new
// segments in the slot ring and walks the in-order run from the base.
// ----------------------------------------------------------------------------
module srr_front import srr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  srr_seg_if.sink     seg_i,
  input  logic        q_empty_i,
  input  logic        q_full_i,
  input  logic        finished_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_CLASS = 4'b0010,
    F_RD    = 4'b0100,
    F_PUSH  = 4'b1000
  } front_state_e;

  front_state_e state_q, state_d;

  logic             fin_q;
  logic [SEQ_W-1:0] seq_q;
  logic [SEQ_W-1:0] len_q;
  logic [TAG_W-1:0] tag_q;

  logic [SEQ_W-1:0]  base_q, base_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [WINDOW-1:0] held_q, held_d;

  logic [LEN_W-1:0] mem_len [WINDOW];
  logic [TAG_W-1:0] mem_tag [WINDOW];
  logic [LEN_W-1:0] rd_len_q;
  logic [TAG_W-1:0] rd_tag_q;

  logic             accept;
  logic             below;
  logic [SEQ_W-1:0] off;
  logic             in_win;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] head_nxt;
  logic [LEN_W-1:0] len_clamped;
  logic             wr_en;

  assign seg_i.ready = (state_q == F_IDLE) && q_empty_i;
  assign accept      = seg_i.valid && seg_i.ready;

  assign below       = seq_q < base_q;
  assign off         = seq_q - base_q;
  assign in_win      = off < SEQ_W'(WINDOW);
  assign idx         = head_q + off[IDX_W-1:0];
  assign head_nxt    = head_q + IDX_W'(1);
  assign len_clamped = (len_q > SEQ_W'(MAX_SEG)) ? LEN_W'(MAX_SEG) : len_q[LEN_W-1:0];

  always_comb begin
    state_d = state_q;
    base_d  = base_q;
    head_d  = head_q;
    held_d  = held_q;
    wr_en   = 1'b0;
    push_o  = 1'b0;
    cmd_o   = '{kind: KIND_ACK, value: '0, tag: '0, len: '0, last: 1'b1};
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_CLASS;
        end
      end
      F_CLASS: begin
        if (finished_i) begin
          state_d = F_IDLE;
        end else if (fin_q) begin
          cmd_o.kind  = KIND_STOP;
          cmd_o.value = len_q;
          if (!q_full_i) begin
            push_o  = 1'b1;
            state_d = F_IDLE;
          end
        end else if (below) begin
          cmd_o.value = seq_q;
          if (!q_full_i) begin
            push_o  = 1'b1;
            state_d = F_IDLE;
          end
        end else if (!in_win || held_q[idx]) begin
          state_d = F_IDLE;
        end else begin
          // New segment: ack it, and if it sits at the base start releasing.
          cmd_o.value = seq_q;
          cmd_o.last  = (off[IDX_W-1:0] != '0);
          if (!q_full_i) begin
            push_o      = 1'b1;
            wr_en       = 1'b1;
            held_d[idx] = 1'b1;
            state_d     = (off[IDX_W-1:0] == '0) ? F_RD : F_IDLE;
          end
        end
      end
      F_RD: begin
        state_d = F_PUSH;
      end
      F_PUSH: begin
        cmd_o.kind = KIND_DELIVER;
        cmd_o.tag  = rd_tag_q;
        cmd_o.len  = rd_len_q;
        cmd_o.last = !held_q[head_nxt];
        if (!q_full_i) begin
          push_o         = 1'b1;
          held_d[head_q] = 1'b0;
          head_d         = head_nxt;
          base_d         = base_q + SEQ_W'(1);
          state_d        = held_q[head_nxt] ? F_RD : F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      base_q  <= '0;
      head_q  <= '0;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      head_q  <= head_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fin_q <= seg_i.finish;
      seq_q <= seg_i.seq_num;
      len_q <= seg_i.seg_length;
      tag_q <= seg_i.payload_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_len[idx] <= len_clamped;
      mem_tag[idx] <= tag_q;
    end
    rd_len_q <= mem_len[head_q];
    rd_tag_q <= mem_tag[head_q];
  end

endmodule

/* rtl/core/srr_queue.sv */
// ----------------------------------------------------------------------------
// Selective-repeat receiver command queue
// Small FIFO of commands between the front end and the result stage.
// ----------------------------------------------------------------------------
module srr_queue import srr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  cmd_i,
  output logic  full_o,
  input  logic  pop_i,
  output cmd_t  cmd_o,
  output logic  empty_o
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entries[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* rtl/core/srr_back.sv */
// ----------------------------------------------------------------------------
// Selective-repeat receiver result stage
// Turns commands into result items, keeps the byte count and the done state.
// ----------------------------------------------------------------------------
module srr_back import srr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        finished_o,
  srr_res_if.source   res_o
);

  logic             out_valid_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SEQ_W-1:0] total_q, total_d;
  logic             known_q, known_d;
  logic             finished_q;
  logic             done;

  logic [1:0]       kind_q;
  logic [SEQ_W-1:0] ack_q;
  logic [TAG_W-1:0] tag_q;
  logic [LEN_W-1:0] len_q;
  logic [CNT_W-1:0] bytes_q;
  logic             done_q;
  logic             last_q;

  assign pop_o = !q_empty_i && (!out_valid_q || res_o.ready);

  always_comb begin
    cnt_d   = cnt_q;
    total_d = total_q;
    known_d = known_q;
    if (cmd_i.kind == KIND_DELIVER) begin
      cnt_d = cnt_q + CNT_W'(cmd_i.len);
    end
    if (cmd_i.kind == KIND_STOP) begin
      total_d = cmd_i.value;
      known_d = 1'b1;
    end
  end

  assign done = known_d && (cnt_d == CNT_W'(total_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      total_q     <= '0;
      known_q     <= 1'b0;
      finished_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_d;
        total_q     <= total_d;
        known_q     <= known_d;
        if (cmd_i.last && done) begin
          finished_q <= 1'b1;
        end
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q  <= cmd_i.kind;
      ack_q   <= (cmd_i.kind == KIND_ACK) ? cmd_i.value : '0;
      tag_q   <= (cmd_i.kind == KIND_DELIVER) ? cmd_i.tag : '0;
      len_q   <= (cmd_i.kind == KIND_DELIVER) ? cmd_i.len : '0;
      bytes_q <= cnt_d;
      done_q  <= done;
      last_q  <= cmd_i.last;
    end
  end

  assign finished_o            = finished_q;
  assign res_o.valid           = out_valid_q;
  assign res_o.kind            = kind_q;
  assign res_o.ack_seq         = ack_q;
  assign res_o.deliver_tag     = tag_q;
  assign res_o.deliver_length  = len_q;
  assign res_o.bytes_delivered = bytes_q;
  assign res_o.done_res        = done_q;
  assign res_o.last            = last_q;

endmodule

/* rtl/core/selective_repeat_receiver_unit.sv */
// ----------------------------------------------------------------------------
// Selective-repeat receiver unit
// Receive window of a selective-repeat link: acks, stop acks, in-order release.
// ----------------------------------------------------------------------------
// Segment headers enter on seg_i and result items leave on res_o, both
// valid/ready channels. Each header gives zero or more result items; the one
// with last set closes the results of that header. A new data segment inside
// the window is acked and stored; when it lands on the window base, the run of
// held segments from the base onward is released in order as delivery items.
// A segment below the base is acked again. A finish header gives a stop ack.
// Once delivered bytes reach the announced total, later headers are taken
// and dropped without a result.
// The front end takes a header and classifies it, then for each released
// segment reads the slot and pushes the delivery. The result stage drains one
// item per cycle into its output register while the result side is ready. The
// next header is taken only once the slot-ring walk is over and the command
// queue has drained.
// Reset empties the window (all slots free, base zero) and the byte count.
// When the result side stalls, the command queue fills and then the front
// end holds; seg_i.ready stays low until the queue has drained.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_unit import srr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  srr_seg_if.sink   seg_i,
  srr_res_if.source res_o
);

  // Commands from the classifier toward the result stage.
  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  // The result stage owns the done state; the front end drops headers once
  // it is set.
  logic finished;

  srr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seg_i      (seg_i),
    .q_empty_i  (q_empty),
    .q_full_i   (q_full),
    .finished_i (finished),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  srr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .cmd_o   (queue_cmd),
    .empty_o (q_empty)
  );

  srr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .cmd_i      (queue_cmd),
    .pop_o      (pop),
    .finished_o (finished),
    .res_o      (res_o)
  );

endmodule
